FILE: src/scm_pkg.sv
`timescale 1ns / 1ps

package scm_pkg;

    localparam int WORD_BITS = 64;
    localparam int LIMB_BITS = 32;
    localparam int FIELD_BITS = 63;

    localparam logic [63:0] WORD_MASK =
        (WORD_BITS >= 64) ? {64{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);

    typedef struct packed {
        logic [63:0] coef;
        logic [63:0] prime;
        logic [63:0] mult;
        logic [63:0] quot;
        logic        last;
    } t_in_beat;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] prime;
        logic        last;
    } t_red_beat;

endpackage

FILE: src/scm_pipe.sv
`timescale 1ns / 1ps

module scm_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  scm_pkg::t_in_beat    i_beat,
    output logic                 o_valid,
    output scm_pkg::t_red_beat   o_beat
);

    localparam int L = scm_pkg::LIMB_BITS;

    // stage 1: 32x32 partial products
    logic        r_s1_valid;
    logic [63:0] r_cq00, r_cq01, r_cq10, r_cq11;
    logic [63:0] r_cm00;
    logic [31:0] r_cm01, r_cm10;
    logic [63:0] r_s1_prime;
    logic        r_s1_last;

    logic [63:0] n_cq00, n_cq01, n_cq10, n_cq11, n_cm00;
    logic [31:0] n_cm01, n_cm10;

    always_comb begin
        n_cq00 = {32'd0, i_beat.coef[L-1:0]} * {32'd0, i_beat.quot[L-1:0]};
        n_cq01 = {32'd0, i_beat.coef[L-1:0]} * {32'd0, i_beat.quot[2*L-1:L]};
        n_cq10 = {32'd0, i_beat.coef[2*L-1:L]} * {32'd0, i_beat.quot[L-1:0]};
        n_cq11 = {32'd0, i_beat.coef[2*L-1:L]} * {32'd0, i_beat.quot[2*L-1:L]};
        n_cm00 = {32'd0, i_beat.coef[L-1:0]} * {32'd0, i_beat.mult[L-1:0]};
        n_cm01 = i_beat.coef[L-1:0] * i_beat.mult[2*L-1:L];
        n_cm10 = i_beat.coef[2*L-1:L] * i_beat.mult[L-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cq00     <= n_cq00;
            r_cq01     <= n_cq01;
            r_cq10     <= n_cq10;
            r_cq11     <= n_cq11;
            r_cm00     <= n_cm00;
            r_cm01     <= n_cm01;
            r_cm10     <= n_cm10;
            r_s1_prime <= i_beat.prime;
            r_s1_last  <= i_beat.last;
        end
    end

    // stage 2: estimate q and coef*mult
    logic        r_s2_valid;
    logic [63:0] r_q, r_s2_cm, r_s2_prime;
    logic        r_s2_last;

    logic [127:0] n_prod;
    logic [63:0]  n_q, n_cm;

    always_comb begin
        n_prod = {64'd0, r_cq00} + ({64'd0, r_cq01} << L) + ({64'd0, r_cq10} << L)
               + {r_cq11, 64'd0};
        n_q    = 64'(n_prod >> scm_pkg::WORD_BITS) & scm_pkg::WORD_MASK;
        n_cm   = (r_cm00 + {r_cm01 + r_cm10, 32'd0}) & scm_pkg::WORD_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_q        <= n_q;
            r_s2_cm    <= n_cm;
            r_s2_prime <= r_s1_prime;
            r_s2_last  <= r_s1_last;
        end
    end

    // stage 3: q*prime partial products
    logic        r_s3_valid;
    logic [63:0] r_qp00;
    logic [31:0] r_qp01, r_qp10;
    logic [63:0] r_s3_cm, r_s3_prime;
    logic        r_s3_last;

    logic [63:0] n_qp00;
    logic [31:0] n_qp01, n_qp10;

    always_comb begin
        n_qp00 = {32'd0, r_q[L-1:0]} * {32'd0, r_s2_prime[L-1:0]};
        n_qp01 = r_q[L-1:0] * r_s2_prime[2*L-1:L];
        n_qp10 = r_q[2*L-1:L] * r_s2_prime[L-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_qp00     <= n_qp00;
            r_qp01     <= n_qp01;
            r_qp10     <= n_qp10;
            r_s3_cm    <= r_s2_cm;
            r_s3_prime <= r_s2_prime;
            r_s3_last  <= r_s2_last;
        end
    end

    // stage 4: r = coef*mult - q*prime, in [0, 2*prime)
    logic        r_s4_valid;
    logic [63:0] r_rem, r_s4_prime;
    logic        r_s4_last;

    logic [63:0] n_qp, n_rem;

    always_comb begin
        n_qp  = r_qp00 + {r_qp01 + r_qp10, 32'd0};
        n_rem = (r_s3_cm - n_qp) & scm_pkg::WORD_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (i_adv) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem      <= n_rem;
            r_s4_prime <= r_s3_prime;
            r_s4_last  <= r_s3_last;
        end
    end

    assign o_valid     = r_s4_valid;
    assign o_beat.rem   = r_rem;
    assign o_beat.prime = r_s4_prime;
    assign o_beat.last  = r_s4_last;

endmodule

FILE: src/shoup_const_modmul.sv
// Shoup modular multiplication by a precomputed constant.
// Throughput: one beat per cycle unless the output stalls; four multiply/add
// stages plus the final reduction and output register, all advancing together.
// Reset: synchronous, active low; clears all valid bits, no data is flushed.
`timescale 1ns / 1ps

module shoup_const_modmul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [scm_pkg::FIELD_BITS-1:0]       i_coefficient,
    input  logic [scm_pkg::FIELD_BITS-1:0]       i_modulus,
    input  logic [scm_pkg::FIELD_BITS-1:0]       i_multiplier,
    input  logic [63:0]                          i_multiplier_quotient,
    input  logic                                 i_end_in,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [scm_pkg::FIELD_BITS-1:0]       o_product,
    output logic                                 o_end_out
);

    logic                adv;
    scm_pkg::t_in_beat   in_beat;
    scm_pkg::t_red_beat  red_beat;
    logic                red_valid;

    logic                r_out_valid;
    logic [scm_pkg::FIELD_BITS-1:0] r_product;
    logic                r_end;

    logic [63:0]         n_red;

    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;

    always_comb begin
        in_beat.coef  = {1'b0, i_coefficient} & scm_pkg::WORD_MASK;
        in_beat.prime = {1'b0, i_modulus} & scm_pkg::WORD_MASK;
        in_beat.mult  = {1'b0, i_multiplier} & scm_pkg::WORD_MASK;
        in_beat.quot  = i_multiplier_quotient & scm_pkg::WORD_MASK;
        in_beat.last  = i_end_in;
    end

    scm_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_beat  (in_beat),
        .o_valid (red_valid),
        .o_beat  (red_beat)
    );

    always_comb begin
        if (red_beat.rem >= red_beat.prime) begin
            n_red = (red_beat.rem - red_beat.prime) & scm_pkg::WORD_MASK;
        end else begin
            n_red = red_beat.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= red_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_product <= n_red[scm_pkg::FIELD_BITS-1:0];
            r_end     <= red_beat.last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_product = r_product;
    assign o_end_out = r_end;

endmodule

FILE: src/scm_checker.sv
`timescale 1ns / 1ps

module scm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic [scm_pkg::FIELD_BITS-1:0] o_product,
    input  logic                           o_end_out
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled output beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_product) && $stable(o_end_out)))
        else $error("stalled output beat changed");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> o_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind shoup_const_modmul scm_checker u_scm_checker (.*);

FILE: dv/shoup_const_modmul_tb.sv
`timescale 1ns / 1ps

module shoup_const_modmul_tb;

    localparam int FIELD_BITS = scm_pkg::FIELD_BITS;
    localparam int WORD_BITS = scm_pkg::WORD_BITS;
    localparam logic [63:0] WORD_MASK = scm_pkg::WORD_MASK;

    localparam logic [FIELD_BITS-1:0] PMAX = {FIELD_BITS{1'b1}};
    localparam int HOLD_CYCLES = 160;
    localparam int PHASE_BEATS = 390;

    typedef struct packed {
        logic [FIELD_BITS-1:0] coef;
        logic [FIELD_BITS-1:0] modulus;
        logic [FIELD_BITS-1:0] mult;
        logic [63:0]           quot;
        logic                  last;
    } t_operand;

    typedef struct packed {
        logic [FIELD_BITS-1:0] product;
        logic                  last;
    } t_product;

    typedef struct packed {
        t_operand              op;
        logic                  auto_quot;
        logic                  typed;
        logic [FIELD_BITS-1:0] product;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [FIELD_BITS-1:0] i_coefficient = '0;
    logic [FIELD_BITS-1:0] i_modulus = '0;
    logic [FIELD_BITS-1:0] i_multiplier = '0;
    logic [63:0]           i_multiplier_quotient = '0;
    logic                  i_end_in = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [FIELD_BITS-1:0] o_product;
    logic                  o_end_out;

    t_product pending_products[$];
    t_dir_row dir_tab[$];

    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    bit  hold_req = 1'b0;
    logic hold_stall;
    int  error_cnt = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  held_cycles = 0;

    shoup_const_modmul uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_coefficient         (i_coefficient),
        .i_modulus             (i_modulus),
        .i_multiplier          (i_multiplier),
        .i_multiplier_quotient (i_multiplier_quotient),
        .i_end_in              (i_end_in),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_product             (o_product),
        .o_end_out             (o_end_out)
    );

    function automatic logic [FIELD_BITS-1:0] shoup_mulmod(input t_operand op);
        logic [63:0]  coef_w;
        logic [63:0]  prime_w;
        logic [63:0]  mult_w;
        logic [63:0]  quot_w;
        logic [63:0]  est;
        logic [63:0]  rem;
        logic [127:0] wide;
        coef_w = {1'b0, op.coef} & WORD_MASK;
        prime_w = {1'b0, op.modulus} & WORD_MASK;
        mult_w = {1'b0, op.mult} & WORD_MASK;
        quot_w = op.quot & WORD_MASK;
        wide = {64'd0, coef_w} * {64'd0, quot_w};
        wide = wide >> WORD_BITS;
        est = wide[63:0] & WORD_MASK;
        rem = (coef_w * mult_w - est * prime_w) & WORD_MASK;
        if (rem >= prime_w) begin
            rem = (rem - prime_w) & WORD_MASK;
        end
        return rem[FIELD_BITS-1:0];
    endfunction

    // floor(mult * 2^W / modulus)
    function automatic logic [63:0] shoup_quotient(input logic [FIELD_BITS-1:0] mult,
                                                   input logic [FIELD_BITS-1:0] modulus);
        logic [127:0] num;
        logic [127:0] den;
        num = {64'd0, {1'b0, mult} & WORD_MASK};
        num = num << WORD_BITS;
        den = {64'd0, {1'b0, modulus} & WORD_MASK};
        if (den == 0) begin
            return '0;
        end
        num = num / den;
        return num[63:0] & WORD_MASK;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_below(input logic [FIELD_BITS-1:0] modulus);
        logic [63:0] r;
        case ($urandom_range(9))
            0: return '0;
            1: return modulus - 1'b1;
            default: begin
                r = rand_word() % {1'b0, modulus};
                return r[FIELD_BITS-1:0];
            end
        endcase
    endfunction

    function automatic t_operand random_operand();
        t_operand    op;
        logic [63:0] r;
        r = rand_word();
        op.last = ($urandom_range(15) == 0);
        case ($urandom_range(3))
            0: op.modulus = r[FIELD_BITS-1:0] | (63'd1 << (FIELD_BITS - 1));
            1: op.modulus = FIELD_BITS'($urandom_range(1000, 2));
            2: begin
                r = r >> $urandom_range(62, 1);
                op.modulus = r[FIELD_BITS-1:0];
            end
            default: op.modulus = PMAX - FIELD_BITS'($urandom_range(1000, 0));
        endcase
        if (op.modulus < 2) begin
            op.modulus = 2;
        end
        op.coef = pick_below(op.modulus);
        op.mult = pick_below(op.modulus);
        op.quot = shoup_quotient(op.mult, op.modulus);
        // malformed beats
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0: begin
                    r = rand_word();
                    op.coef = r[FIELD_BITS-1:0];
                    r = rand_word();
                    op.modulus = r[FIELD_BITS-1:0];
                    r = rand_word();
                    op.mult = r[FIELD_BITS-1:0];
                    op.quot = rand_word();
                end
                1: op.quot = op.quot ^ (64'd1 << $urandom_range(63, 0));
                2: op.coef = op.coef + op.modulus;
                default: op.modulus = FIELD_BITS'($urandom_range(1, 0));
            endcase
        end
        return op;
    endfunction

    task automatic add_row(input logic [FIELD_BITS-1:0] coef, input logic [FIELD_BITS-1:0] modulus,
                           input logic [FIELD_BITS-1:0] mult, input logic [63:0] quot,
                           input logic auto_quot, input logic last, input logic typed,
                           input logic [FIELD_BITS-1:0] product);
        t_dir_row row;
        row.op.coef = coef;
        row.op.modulus = modulus;
        row.op.mult = mult;
        row.op.quot = auto_quot ? shoup_quotient(mult, modulus) : quot;
        row.op.last = last;
        row.auto_quot = auto_quot;
        row.typed = typed;
        row.product = product;
        dir_tab.push_back(row);
    endtask

    task automatic offer(input t_operand op, input logic typed,
                         input logic [FIELD_BITS-1:0] typed_product);
        t_product want;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_coefficient <= op.coef;
        i_modulus <= op.modulus;
        i_multiplier <= op.mult;
        i_multiplier_quotient <= op.quot;
        i_end_in <= op.last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        want.product = typed ? typed_product : shoup_mulmod(op);
        want.last = op.last;
        pending_products.push_back(want);
        beats_in++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= hold_stall || ($urandom_range(99) < sink_stall_pct);
        end
    end

    // long output hold-off so the pipe fills and backs up
    initial begin : long_hold
        hold_stall = 1'b0;
        wait (hold_req);
        @(posedge i_clk);
        hold_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_stall <= 1'b0;
    end

    always @(posedge i_clk) begin : check_out
        t_product want;
        if (i_rst_n) begin
            if (o_stall) begin
                held_cycles++;
            end
            if (o_valid && !i_stall) begin
                beats_out++;
                if (pending_products.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= 10) begin
                        $display("ERROR: unexpected beat product=%h end=%b", o_product, o_end_out);
                    end
                end else begin
                    want = pending_products.pop_front();
                    if (o_product !== want.product || o_end_out !== want.last) begin
                        error_cnt++;
                        if (error_cnt <= 10) begin
                            $display("ERROR: beat %0d exp product=%h end=%b got product=%h end=%b",
                                     beats_out, want.product, want.last, o_product, o_end_out);
                        end
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #4000000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int phase;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // coef, modulus, mult, quot, auto quot, end, typed, product
        add_row(63'd0, 63'd1000003, 63'd12345, 64'd0, 1'b1, 1'b0, 1'b1, 63'd0);
        add_row(63'd5, 63'd1000003, 63'd0, 64'd0, 1'b1, 1'b0, 1'b1, 63'd0);
        add_row(63'd1, 63'd1000003, 63'd777, 64'd0, 1'b1, 1'b0, 1'b1, 63'd777);
        add_row(PMAX - 1'b1, PMAX, 63'd1, 64'd0, 1'b1, 1'b0, 1'b1, PMAX - 1'b1);
        add_row(PMAX - 1'b1, PMAX, PMAX - 1'b1, 64'd0, 1'b1, 1'b1, 1'b1, 63'd1);
        add_row(63'd1, 63'd2, 63'd1, 64'd0, 1'b1, 1'b1, 1'b1, 63'd1);
        add_row(63'd2, 63'd3, 63'd2, 64'd0, 1'b1, 1'b0, 1'b1, 63'd1);
        add_row(63'd0, 63'd2, 63'd0, 64'd0, 1'b0, 1'b0, 1'b1, 63'd0);
        add_row(63'h5A5A_5A5A_5A5A_5A5A, PMAX, 63'h2BAD_F00D_1234_5678, 64'd0, 1'b1, 1'b0,
                1'b0, '0);
        add_row(63'h1234_5678_9ABC_DEF0, 63'h1FFF_FFFF_FFFF_FFFF, 63'h0FED_CBA9_8765_4321, 64'd0,
                1'b1, 1'b1, 1'b0, '0);
        add_row(63'h4000_0000_0000_0000 - 1'b1, 63'h4000_0000_0000_0000, 63'd3, 64'd0, 1'b1,
                1'b0, 1'b0, '0);
        add_row(PMAX, 63'h4000_0000_0000_0001, 63'd99, 64'd0, 1'b1, 1'b0, 1'b0, '0);
        add_row(63'd12345, 63'd0, 63'd678, {64{1'b1}}, 1'b0, 1'b0, 1'b0, '0);
        add_row(63'd5, 63'd1, 63'd7, 64'd0, 1'b0, 1'b1, 1'b0, '0);
        add_row(63'd999999, 63'd1000003, 63'd500000, 64'd0, 1'b0, 1'b0, 1'b0, '0);
        add_row(PMAX - 1'b1, PMAX, PMAX - 1'b1, {64{1'b1}}, 1'b0, 1'b0, 1'b0, '0);
        add_row(63'd1000003, 63'd1000003, 63'd1000002, 64'd0, 1'b1, 1'b0, 1'b0, '0);
        add_row(63'd424242, PMAX, PMAX, 64'd0, 1'b1, 1'b0, 1'b0, '0);
        add_row(PMAX, PMAX, PMAX, {64{1'b1}}, 1'b0, 1'b1, 1'b0, '0);
        add_row(63'h7FFF_0000_FFFF_0000, PMAX - 63'd24, 63'h0000_FFFF_0000_FFFF, 64'd0, 1'b1,
                1'b0, 1'b0, '0);
        add_row(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 63'h5555_5555_5555_5554,
                64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b0, '0);

        foreach (dir_tab[k]) begin
            offer(dir_tab[k].op, dir_tab[k].typed, dir_tab[k].product);
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
                default: begin src_idle_pct = 29; sink_stall_pct = 29; end
            endcase
            repeat (PHASE_BEATS) offer(random_operand(), 1'b0, '0);
        end

        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_req = 1'b1;
        repeat (60) offer(random_operand(), 1'b0, '0);

        i_valid <= 1'b0;
        while (pending_products.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);

        $display("summary: %0d beats in, %0d out; directed edge cases plus four idle/stall mixes",
                 beats_in, beats_out);
        $display("summary: input stalled %0d cycles, incl. a %0d-cycle output hold-off; %0d errors",
                 held_cycles, HOLD_CYCLES, error_cnt);
        if (error_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
src/scm_pkg.sv
src/scm_pipe.sv
src/shoup_const_modmul.sv
src/scm_checker.sv
dv/shoup_const_modmul_tb.sv
